// ===== rtl/core/brlm_pkg.sv =====
// Shared types and constants for the binned RMS level meter.
// No dependencies; imported by brlm_rms and binned_rms_level_meter.
package brlm_pkg;

    // Bin layout
    localparam int BINS      = 16;
    localparam int BIN_W     = $clog2(BINS);
    localparam int BIN_CNT_W = $clog2(BINS + 1);

    // Item fields and block counters
    localparam int SAMPLE_W = 16;
    localparam int BS_W     = 13;
    localparam int CH_W     = 4;
    localparam int POS_W    = 13;
    localparam int PHASE_W  = 4;
    localparam int FILL_W   = 9;
    localparam int SQ_W     = 31;
    localparam int SUM_W    = 39;
    localparam int DISP_W   = 4;

    // Frame and bin boundary products
    localparam int FEND_W = POS_W + 1 + CH_W;
    localparam int BEND_W = FILL_W + 1 + CH_W + BIN_CNT_W;

    // Levels, unsigned Q1.15
    localparam int LEVEL_W = 16;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;
    localparam logic [DISP_W-1:0]  DISP_FULL = 4'd8;

    // Smoothing 0.7 / 0.3 and decay 0.85 = 17/20, all through one divide by ten
    localparam int ACC_W         = 21;
    localparam int SMOOTH_OLD_K  = 7;
    localparam int SMOOTH_NEW_K  = 3;
    localparam int DECAY_K       = 17;
    localparam int DIV10_W       = 20;
    localparam logic [DIV10_W-1:0] DIV10_MUL = 20'd838861;
    localparam int DIV10_SHIFT   = 23;
    localparam int PROD_W        = ACC_W + DIV10_W;

    // Mean and root unit
    localparam int MEAN_W = 2 * LEVEL_W;
    localparam int SREM_W = LEVEL_W + 2;
    localparam int CNT_W  = $clog2(SUM_W);

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_CHANNEL_COUNT = '0;
    localparam logic [CH_W-1:0]    CH_RESET          = 4'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_ACCUM,
        S_ROOT_START,
        S_ROOT_WAIT,
        S_SMOOTH_MUL,
        S_SMOOTH_WR,
        S_BLOCK_END,
        S_DECAY_RD,
        S_DECAY_MUL,
        S_DECAY_WR,
        S_REPORT_RD,
        S_REPORT_PUT
    } lm_state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT,
        R_DONE
    } rms_state_t;

    // Request and response between the sequencer and the root unit
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  sum;
        logic [FILL_W-1:0] count;
    } rms_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] rms;
    } rms_rsp_t;

endpackage

// ===== rtl/core/brlm_rms.sv =====
// Bin RMS unit: floor(sum / count) by restoring division, then floor(sqrt).
// One quotient bit, then one root bit per cycle. Depends on brlm_pkg.
module brlm_rms
    import brlm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rms_req_t req,
    output rms_rsp_t rsp
);

    rms_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [FILL_W-1:0]   div_reg, div_next;
    logic [FILL_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [SREM_W-1:0]   srem_reg, srem_next;
    logic [LEVEL_W-1:0]  root_reg, root_next;

    // Division step
    logic [FILL_W:0]     div_trial;
    logic                div_ge;
    // Root step
    logic [SREM_W+1:0]   sq_shift;
    logic [SREM_W+1:0]   sq_trial;
    logic                sq_ge;

    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, div_reg};
    assign sq_shift  = {srem_reg, quo_reg[MEAN_W-1 -: 2]};
    assign sq_trial  = (SREM_W+2)'({root_reg, 2'b01});
    assign sq_ge     = sq_shift >= sq_trial;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (req.start)
                begin
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = R_SQRT;
                end
            end
            R_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = R_DONE;
                end
            end
            R_DONE:  state_next = R_IDLE;
            default: state_next = R_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next  = CNT_W'(SUM_W - 1);
                    div_next  = req.count;
                    rem_next  = '0;
                    quo_next  = req.sum;
                    srem_next = '0;
                    root_next = '0;
                end
            end
            R_DIV:
            begin
                rem_next = div_ge ? FILL_W'(div_trial - {1'b0, div_reg})
                                  : div_trial[FILL_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], div_ge};
                cnt_next = (cnt_reg == '0) ? CNT_W'(LEVEL_W - 1) : cnt_reg - CNT_W'(1);
            end
            R_SQRT:
            begin
                srem_next = sq_ge ? SREM_W'(sq_shift - sq_trial) : SREM_W'(sq_shift);
                root_next = {root_reg[LEVEL_W-2:0], sq_ge};
                quo_next  = {quo_reg[SUM_W-3:0], 2'b00};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        rsp.done = (state_reg == R_DONE);
        rsp.rms  = root_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    // Checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == R_IDLE))
        else $error("root unit started while busy");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == R_DIV) |-> (div_reg != '0))
        else $error("division by an empty bin");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == R_DIV) |-> (rem_reg < div_reg))
        else $error("division remainder out of range");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (rsp.rms <= LEVEL_ONE))
        else $error("bin RMS above full scale");

endmodule

// ===== rtl/core/binned_rms_level_meter.sv =====
// Binned RMS level meter: bin levels in a 16 x 16 synchronous RAM, one sequencer.
// A sample item is evaluated and accumulated; one that closes a bin adds a divide, a root
// and a read-modify-write of its level. The last sample adds a possible bin close, a decay
// of each open bin, a report of every bin and any output stall. Results follow in order.
// Reset: levels read as zero through per-entry valid bits, no clearing pass; counters cleared.
// Depends on brlm_pkg and brlm_rms.
module binned_rms_level_meter
    import brlm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    // Input items
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       cmd,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [BS_W-1:0]            block_samples,
    input  logic                       last_sample,
    // Result items
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [BIN_W-1:0]           bin_number,
    output logic [DISP_W-1:0]          display_level,
    output logic                       final_bin
);

    lm_state_t state_reg, state_next;

    // Configuration
    logic [CH_W-1:0]  ch_reg;
    logic [CH_W-1:0]  ch_eff;
    logic             reg_sel;

    // Latched item
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [BS_W-1:0]            bs_reg, bs_next;
    logic                       last_reg, last_next;

    // Block state
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [POS_W-1:0]     fpos_reg, fpos_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [BIN_CNT_W-1:0] cur_bin_reg, cur_bin_next;
    logic [BIN_W-1:0]     rep_idx_reg, rep_idx_next;

    // Per-item working registers
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              take_reg, take_next;
    logic              close_reg, close_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [BIN_W-1:0]  out_bin_reg, out_bin_next;
    logic [DISP_W-1:0] out_disp_reg, out_disp_next;
    logic              out_final_reg, out_final_next;

    // Level memory with valid bits
    logic [LEVEL_W-1:0] lvl_mem [BINS];
    logic [BINS-1:0]    level_valid_reg;
    logic [LEVEL_W-1:0] lvl_rdata_reg;
    logic               lvl_rvalid_reg;
    logic [BIN_W-1:0]   lvl_raddr;
    logic               lvl_we;
    logic [LEVEL_W-1:0] lvl_wdata;
    logic               clear_all;

    // Datapath terms
    logic                            item_take;
    logic                            out_free;
    logic [LEVEL_W-1:0]              lvl_old;
    logic                            frames_nz;
    logic                            bin_open;
    logic [POS_W:0]                  pos_inc;
    logic [FEND_W-1:0]               frame_end;
    logic                            take_now;
    logic [FILL_W:0]                 fill_inc2;
    logic [BEND_W-1:0]               bin_end;
    logic                            close_now;
    logic signed [2*SAMPLE_W-1:0]    square;
    logic [PHASE_W:0]                phase_inc;
    logic [ACC_W-1:0]                smooth_acc;
    logic [ACC_W-1:0]                decay_acc;
    logic [ACC_W-1:0]                acc_in;
    logic [PROD_W-DIV10_SHIFT-1:0]   smooth_q;
    logic [LEVEL_W-1:0]              smooth_lvl;
    logic [LEVEL_W-1:0]              decay_lvl;
    logic [DISP_W-1:0]               disp;

    rms_req_t rms_req;
    rms_rsp_t rms_rsp;

    // Register port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_CHANNEL_COUNT);
    assign prdata  = reg_sel ? {{(PDATA_W-CH_W){1'b0}}, ch_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= CH_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            ch_reg <= pwdata[CH_W-1:0];
        end
    end

    // Common terms
    assign ch_eff    = (ch_reg == '0) ? CH_W'(1) : ch_reg;
    assign item_take = item_valid && !item_stall;
    assign out_free  = !out_valid_reg || !result_stall;
    assign lvl_old   = lvl_rvalid_reg ? lvl_rdata_reg : '0;
    assign frames_nz = bs_reg >= BS_W'(ch_eff);
    assign bin_open  = cur_bin_reg < BIN_CNT_W'(BINS);

    // Frame within the block: (position + 1) * channels <= block samples
    assign pos_inc   = {1'b0, fpos_reg} + (POS_W+1)'(1);
    assign frame_end = FEND_W'(pos_inc) * FEND_W'(ch_eff);
    assign take_now  = (phase_reg == '0) && (frame_end <= FEND_W'(bs_reg));

    // Bin closes once fill reaches max(1, frames / BINS)
    assign fill_inc2 = {1'b0, fill_reg} + (FILL_W+1)'(2);
    assign bin_end   = BEND_W'(fill_inc2) * BEND_W'(ch_eff) * BEND_W'(BINS);
    assign close_now = take_now && bin_open && (BEND_W'(bs_reg) < bin_end);

    assign square    = sample_reg * sample_reg;
    assign phase_inc = {1'b0, phase_reg} + (PHASE_W+1)'(1);

    // Shared divide-by-ten multiplier operands
    assign smooth_acc = ACC_W'(lvl_old) * ACC_W'(SMOOTH_OLD_K)
                      + ACC_W'(rms_rsp.rms) * ACC_W'(SMOOTH_NEW_K);
    assign decay_acc  = ACC_W'(lvl_old) * ACC_W'(DECAY_K);
    assign acc_in     = (state_reg == S_SMOOTH_MUL) ? smooth_acc : decay_acc;

    assign smooth_q   = prod_reg[PROD_W-1:DIV10_SHIFT];
    assign smooth_lvl = (smooth_q > (PROD_W-DIV10_SHIFT)'(LEVEL_ONE)) ? LEVEL_ONE
                                                                      : smooth_q[LEVEL_W-1:0];
    // 17/20: divide by ten, then halve
    assign decay_lvl  = prod_reg[DIV10_SHIFT+1 +: LEVEL_W];

    // Display value, 8 only at full scale
    assign disp = (lvl_old >= LEVEL_ONE) ? DISP_FULL : DISP_W'(lvl_old[LEVEL_W-2 -: 3]);

    // Root unit
    assign rms_req.start = (state_reg == S_ROOT_START);
    assign rms_req.sum   = sum_reg;
    assign rms_req.count = fill_reg;

    brlm_rms u_rms (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rms_req),
        .rsp   (rms_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_take && !cmd)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:  state_next = S_ACCUM;
            S_ACCUM:
            begin
                if (close_reg)
                begin
                    state_next = S_ROOT_START;
                end
                else if (last_reg)
                begin
                    state_next = S_BLOCK_END;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT_START: state_next = S_ROOT_WAIT;
            S_ROOT_WAIT:
            begin
                if (rms_rsp.done)
                begin
                    state_next = S_SMOOTH_MUL;
                end
            end
            S_SMOOTH_MUL: state_next = S_SMOOTH_WR;
            S_SMOOTH_WR:  state_next = last_reg ? S_BLOCK_END : S_IDLE;
            S_BLOCK_END:
            begin
                if (frames_nz && bin_open && (fill_reg != '0))
                begin
                    state_next = S_ROOT_START;
                end
                else if (frames_nz && bin_open)
                begin
                    state_next = S_DECAY_RD;
                end
                else
                begin
                    state_next = S_REPORT_RD;
                end
            end
            S_DECAY_RD:  state_next = S_DECAY_MUL;
            S_DECAY_MUL: state_next = S_DECAY_WR;
            S_DECAY_WR:
            begin
                if (cur_bin_reg == BIN_CNT_W'(BINS - 1))
                begin
                    state_next = S_REPORT_RD;
                end
                else
                begin
                    state_next = S_DECAY_RD;
                end
            end
            S_REPORT_RD: state_next = S_REPORT_PUT;
            S_REPORT_PUT:
            begin
                if (out_free)
                begin
                    state_next = (rep_idx_reg == BIN_W'(BINS - 1)) ? S_IDLE : S_REPORT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        item_stall     = (state_reg != S_IDLE);
        clear_all      = 1'b0;
        lvl_we         = 1'b0;
        lvl_wdata      = smooth_lvl;
        lvl_raddr      = cur_bin_reg[BIN_W-1:0];

        sample_next    = sample_reg;
        bs_next        = bs_reg;
        last_next      = last_reg;
        phase_next     = phase_reg;
        fpos_next      = fpos_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        cur_bin_next   = cur_bin_reg;
        rep_idx_next   = rep_idx_reg;
        sq_next        = sq_reg;
        take_next      = take_reg;
        close_next     = close_reg;
        prod_next      = prod_reg;

        out_valid_next = out_valid_reg && result_stall;
        out_bin_next   = out_bin_reg;
        out_disp_next  = out_disp_reg;
        out_final_next = out_final_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    clear_all   = cmd;
                    sample_next = sample;
                    bs_next     = block_samples;
                    last_next   = last_sample;
                end
            end
            S_EVAL:
            begin
                sq_next    = square[SQ_W-1:0];
                take_next  = take_now;
                close_next = close_now;
            end
            S_ACCUM:
            begin
                phase_next = (phase_inc >= (PHASE_W+1)'(ch_eff)) ? '0
                                                                 : phase_inc[PHASE_W-1:0];
                if (take_reg)
                begin
                    fpos_next = fpos_reg + POS_W'(1);
                    if (bin_open)
                    begin
                        sum_next  = sum_reg + SUM_W'(sq_reg);
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            S_SMOOTH_MUL, S_DECAY_MUL:
            begin
                prod_next = PROD_W'(acc_in) * PROD_W'(DIV10_MUL);
            end
            S_SMOOTH_WR:
            begin
                lvl_we       = 1'b1;
                lvl_wdata    = smooth_lvl;
                cur_bin_next = cur_bin_reg + BIN_CNT_W'(1);
                fill_next    = '0;
                sum_next     = '0;
            end
            S_DECAY_WR:
            begin
                lvl_we       = 1'b1;
                lvl_wdata    = decay_lvl;
                cur_bin_next = cur_bin_reg + BIN_CNT_W'(1);
            end
            S_REPORT_RD:
            begin
                lvl_raddr = rep_idx_reg;
            end
            S_REPORT_PUT:
            begin
                lvl_raddr = rep_idx_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_bin_next   = rep_idx_reg;
                    out_disp_next  = disp;
                    out_final_next = (rep_idx_reg == BIN_W'(BINS - 1));
                    if (rep_idx_reg == BIN_W'(BINS - 1))
                    begin
                        // End of block: counters and sum back to zero
                        rep_idx_next = '0;
                        phase_next   = '0;
                        fpos_next    = '0;
                        fill_next    = '0;
                        sum_next     = '0;
                        cur_bin_next = '0;
                    end
                    else
                    begin
                        rep_idx_next = rep_idx_reg + BIN_W'(1);
                    end
                end
            end
            default:
            begin
                lvl_we = 1'b0;
            end
        endcase
    end

    assign result_valid  = out_valid_reg;
    assign bin_number    = out_bin_reg;
    assign display_level = out_disp_reg;
    assign final_bin     = out_final_reg;

    // Level RAM, one write and one registered read per cycle. A write cycle also reads the
    // entry it writes, but that read is never used, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[cur_bin_reg[BIN_W-1:0]] <= lvl_wdata;
        end
        lvl_rdata_reg  <= lvl_mem[lvl_raddr];
        lvl_rvalid_reg <= level_valid_reg[lvl_raddr];
    end

    // Valid bits: an entry never written since reset or clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_valid_reg <= '0;
        end
        else if (clear_all)
        begin
            level_valid_reg <= '0;
        end
        else if (lvl_we)
        begin
            level_valid_reg[cur_bin_reg[BIN_W-1:0]] <= 1'b1;
        end
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            fpos_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            cur_bin_reg   <= '0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fpos_reg      <= fpos_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            cur_bin_reg   <= cur_bin_next;
            rep_idx_reg   <= rep_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        bs_reg        <= bs_next;
        last_reg      <= last_next;
        sq_reg        <= sq_next;
        take_reg      <= take_next;
        close_reg     <= close_next;
        prod_reg      <= prod_next;
        out_bin_reg   <= out_bin_next;
        out_disp_reg  <= out_disp_next;
        out_final_reg <= out_final_next;
    end

    // Checks
    a_final_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_bin) |-> (bin_number == BIN_W'(BINS - 1)))
        else $error("final flag on a bin other than the last");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_bin_reg <= BIN_CNT_W'(BINS))
        else $error("current bin beyond the bin count");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_we |-> (lvl_wdata <= LEVEL_ONE))
        else $error("level written above full scale");

    a_block_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT_PUT && state_next == S_IDLE) |=>
        (fpos_reg == '0 && fill_reg == '0 && cur_bin_reg == '0 && sum_reg == '0))
        else $error("block counters not cleared after report");

    a_sample_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && !cmd) |=> (state_reg == S_EVAL))
        else $error("accepted sample item not evaluated");

endmodule
